@@ rtl/core/mkcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mkcs_pkg
// Types, widths and key comparison functions shared by the choice sorter.
// ----------------------------------------------------------------------------
package mkcs_pkg;

    localparam int ID_W            = 6;
    localparam int EMS_W           = 16;
    localparam int MAXH_W          = 16;
    localparam int CNT_W           = 8;
    localparam int FRAME_W         = 20;
    localparam int MAX_CHOICES_DEF = 64;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [EMS_W-1:0]   ems_hole;
        logic [MAXH_W-1:0]  max_hole;
        logic [CNT_W-1:0]   hole_count;
        logic [FRAME_W-1:0] frame;
    } payload_t;

    typedef struct packed {
        logic     valid;
        payload_t pay;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '0;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SORT,
        OP_SHIFT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic parity;
        logic frame_present;
    } ctrl_t;

    // True when a goes strictly before b on the three primary keys.
    function automatic logic before3(input payload_t a, input payload_t b);
        logic res;
        if (a.ems_hole != b.ems_hole)
        begin
            res = (a.ems_hole > b.ems_hole);
        end
        else if (a.max_hole != b.max_hole)
        begin
            res = (a.max_hole > b.max_hole);
        end
        else if (a.hole_count != b.hole_count)
        begin
            res = (a.hole_count < b.hole_count);
        end
        else
        begin
            res = 1'b0;
        end
        return res;
    endfunction

    // Full ordering, with the frame address as the final tie break when fp is set.
    function automatic logic before_full(input payload_t a, input payload_t b,
                                         input logic fp);
        logic ties;
        ties = (a.ems_hole == b.ems_hole) && (a.max_hole == b.max_hole)
               && (a.hole_count == b.hole_count);
        return before3(a, b) || (ties && fp && (a.frame > b.frame));
    endfunction

endpackage

@@ rtl/core/mkcs_cell.sv @@
// ----------------------------------------------------------------------------
// mkcs_cell
// One slot of the sorting chain: stable insertion, neighbor swap, shift out.
// ----------------------------------------------------------------------------
module mkcs_cell
    import mkcs_pkg::*;
#(
    parameter logic IDX_ODD = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctrl_t  ctrl,
    input  entry_t new_item,
    input  entry_t prev_data,
    input  logic   prev_worse,
    input  logic   prev_swap,
    input  entry_t next_data,
    output entry_t data,
    output logic   worse,
    output logic   swap
);

    logic     valid_reg;
    logic     valid_next;
    payload_t pay_reg;
    payload_t pay_next;
    entry_t   ent_next;

    assign data = '{valid: valid_reg, pay: pay_reg};

    // An empty slot counts as worse than any new word, so the worse flags
    // along the chain form a run of zeros followed by a run of ones.
    assign worse = !valid_reg || before3(new_item.pay, pay_reg);

    // This cell is the left half of a compare pair when its index parity
    // matches the current round.
    assign swap = (ctrl.op == OP_SORT) && (IDX_ODD == ctrl.parity) && valid_reg
                  && next_data.valid
                  && before_full(next_data.pay, pay_reg, ctrl.frame_present);

    always_comb
    begin
        ent_next = data;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (worse)
                begin
                    ent_next = prev_worse ? prev_data : new_item;
                end
            end
            OP_SORT:
            begin
                if (swap)
                begin
                    ent_next = next_data;
                end
                else if (prev_swap)
                begin
                    ent_next = prev_data;
                end
            end
            OP_SHIFT:
            begin
                ent_next = next_data;
            end
            default:
            begin
                ent_next = data;
            end
        endcase
        valid_next = ent_next.valid;
        pay_next   = ent_next.pay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

endmodule

@@ rtl/core/mkcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mkcs_ctrl
// Sequencer for load, frame tie-break sorting rounds and result emission.
// ----------------------------------------------------------------------------
module mkcs_ctrl
    import mkcs_pkg::*;
#(
    parameter int MAX_CHOICES = MAX_CHOICES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  last,
    input  logic  chain_full,
    input  logic  head_last,
    input  logic  out_ready,
    input  logic  frame_present,
    output logic  in_ready,
    output logic  out_valid,
    output ctrl_t ctrl
);

    localparam int ROUND_W = $clog2(MAX_CHOICES);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next         = state_reg;
        round_next         = round_reg;
        ctrl.op            = OP_HOLD;
        ctrl.parity        = round_reg[0];
        ctrl.frame_present = frame_present;
        unique case (state_reg)
            ST_LOAD:
            begin
                round_next = '0;
                if (in_valid)
                begin
                    // A word that finds the chain full is dropped.
                    if (!chain_full)
                    begin
                        ctrl.op = OP_INSERT;
                    end
                    if (last)
                    begin
                        state_next = frame_present ? ST_SORT : ST_EMIT;
                    end
                end
            end
            ST_SORT:
            begin
                ctrl.op    = OP_SORT;
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(MAX_CHOICES - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    ctrl.op = OP_SHIFT;
                    if (head_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

endmodule

@@ rtl/core/multi_key_choice_sorter.sv @@
// ----------------------------------------------------------------------------
// multi_key_choice_sorter
// Stable multi-key sorter of configuration choices on a chain of cells.
// ----------------------------------------------------------------------------
// Choices arrive on the input channel (in_valid/in_ready), one word per
// cycle. Each word is inserted into its place in a chain of MAX_CHOICES
// cells by EMS hole, largest hole and hole count; equal words keep arrival
// order. Words that find the chain full are dropped. The word marked last
// closes the set and the input channel stays low on ready until the whole
// set has been delivered.
// With frame_present clear, the first sorted id is offered in the cycle after
// the last word is accepted. With frame_present set, MAX_CHOICES rounds of
// neighbor compare-and-swap across the chain apply the frame address tie
// break before the first id is offered.
// Results leave on the output channel (out_valid/out_ready) from the head
// cell, one word per cycle; each accepted word shifts the chain by one.
// A stalled receiver simply holds the chain. end_of_list marks the final id.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) is always ready.
// Reset empties every cell and clears frame_present.
// ----------------------------------------------------------------------------
module multi_key_choice_sorter
    import mkcs_pkg::*;
#(
    parameter int MAX_CHOICES = MAX_CHOICES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ID_W-1:0]    choice_id,
    input  logic [EMS_W-1:0]   ems_hole_size,
    input  logic [MAXH_W-1:0]  max_hole_size,
    input  logic [CNT_W-1:0]   hole_count,
    input  logic [FRAME_W-1:0] frame_address,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_W-1:0]    sorted_id,
    output logic               end_of_list,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    logic   frame_present_reg;
    logic   frame_present_next;
    ctrl_t  ctrl;
    entry_t new_item;
    entry_t cell_q [MAX_CHOICES];
    logic   worse  [MAX_CHOICES];
    logic   swap   [MAX_CHOICES];

    assign cfg_ready          = 1'b1;
    assign frame_present_next = (cfg_valid && cfg_ready) ? cfg_data : frame_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_present_reg <= 1'b0;
        end
        else
        begin
            frame_present_reg <= frame_present_next;
        end
    end

    assign new_item.valid          = 1'b1;
    assign new_item.pay.id         = choice_id;
    assign new_item.pay.ems_hole   = ems_hole_size;
    assign new_item.pay.max_hole   = max_hole_size;
    assign new_item.pay.hole_count = hole_count;
    assign new_item.pay.frame      = frame_address;

    mkcs_ctrl #(
        .MAX_CHOICES (MAX_CHOICES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last          (last),
        .chain_full    (cell_q[MAX_CHOICES-1].valid),
        .head_last     (end_of_list),
        .out_ready     (out_ready),
        .frame_present (frame_present_reg),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .ctrl          (ctrl)
    );

    for (genvar i = 0; i < MAX_CHOICES; i++)
    begin : g_cell
        entry_t prev_data;
        entry_t next_data;
        logic   prev_worse;
        logic   prev_swap;

        if (i == 0)
        begin : g_head
            assign prev_data  = ENTRY_EMPTY;
            assign prev_worse = 1'b0;
            assign prev_swap  = 1'b0;
        end
        else
        begin : g_body
            assign prev_data  = cell_q[i-1];
            assign prev_worse = worse[i-1];
            assign prev_swap  = swap[i-1];
        end

        if (i == MAX_CHOICES - 1)
        begin : g_tail
            assign next_data = ENTRY_EMPTY;
        end
        else
        begin : g_link
            assign next_data = cell_q[i+1];
        end

        mkcs_cell #(
            .IDX_ODD (1'(i % 2))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_item   (new_item),
            .prev_data  (prev_data),
            .prev_worse (prev_worse),
            .prev_swap  (prev_swap),
            .next_data  (next_data),
            .data       (cell_q[i]),
            .worse      (worse[i]),
            .swap       (swap[i])
        );
    end

    assign sorted_id   = cell_q[0].pay.id;
    assign end_of_list = !cell_q[1].valid;

`ifndef SYNTHESIS
    // A result is only offered while the head cell holds a word.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_q[0].valid)
        else $error("result offered from an empty head cell");

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    // After the final id the chain is empty and loading resumes.
    a_end_resume: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_list) |=> (in_ready && !cell_q[0].valid))
        else $error("chain not cleared after the final id");

    // Between ids of one run the output stays valid.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !end_of_list) |=> out_valid)
        else $error("run broken before end_of_list");
`endif

endmodule

@@ bench/multi_key_choice_sorter_tb.sv @@
// ----------------------------------------------------------------------------
// multi_key_choice_sorter_tb
// Self-checking bench for the stable multi-key choice sorter.
// ----------------------------------------------------------------------------
// Sets of choices are fed one word at a time. A local sorter ranks each set
// when its closing word is accepted and queues the ids it must produce. The
// output side checks every id word against that queue. The frame address tie
// break is toggled between phases. Sender gaps and receiver stalls vary from
// phase to phase. Set sizes range from one choice to past the capacity.
// ----------------------------------------------------------------------------
module multi_key_choice_sorter_tb;
    import mkcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = MAX_CHOICES_DEF;
    localparam int QUIET_LIMIT = 3000;

    typedef struct {
        bit [ID_W-1:0]    id;
        bit [EMS_W-1:0]   ems_hole;
        bit [MAXH_W-1:0]  max_hole;
        bit [CNT_W-1:0]   hole_count;
        bit [FRAME_W-1:0] frame;
        bit               last;
        bit               hold;     // wait for every owed id before sending
    } choice_t;

    typedef struct {
        bit [ID_W-1:0] id;
        bit            eol;
    } id_word_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [ID_W-1:0]    choice_id     = '0;
    logic [EMS_W-1:0]   ems_hole_size = '0;
    logic [MAXH_W-1:0]  max_hole_size = '0;
    logic [CNT_W-1:0]   hole_count    = '0;
    logic [FRAME_W-1:0] frame_address = '0;
    logic               last          = 1'b0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [ID_W-1:0]    sorted_id;
    logic               end_of_list;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic               cfg_data      = 1'b0;

    choice_t  choice_feed[$];
    choice_t  open_set[$];
    id_word_t due_ids[$];
    choice_t  on_wire;
    choice_t  next_choice;
    id_word_t want;
    bit       frame_on       = 1'b0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       ids_promised   = 0;
    int       ids_delivered  = 0;
    int       mismatches     = 0;
    int       quiet_cycles   = 0;

    multi_key_choice_sorter #(
        .MAX_CHOICES (CAPACITY)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .choice_id     (choice_id),
        .ems_hole_size (ems_hole_size),
        .max_hole_size (max_hole_size),
        .hole_count    (hole_count),
        .frame_address (frame_address),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_id     (sorted_id),
        .end_of_list   (end_of_list),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // True when choice a must come strictly ahead of choice b.
    function automatic bit ranks_ahead(input choice_t a, input choice_t b, input bit fp);
        if (a.ems_hole != b.ems_hole)
            return a.ems_hole > b.ems_hole;
        if (a.max_hole != b.max_hole)
            return a.max_hole > b.max_hole;
        if (a.hole_count != b.hole_count)
            return a.hole_count < b.hole_count;
        if (fp)
            return a.frame > b.frame;
        return 1'b0;
    endfunction

    // Store an accepted choice; on the closing word rank the set and owe its ids.
    task automatic take_choice(input choice_t c);
        choice_t  ranked[$];
        id_word_t w;
        int       j;
        if (open_set.size() < CAPACITY)
            open_set.push_back(c);
        if (c.last)
        begin
            foreach (open_set[i])
            begin
                j = ranked.size();
                // Move ahead only past strictly worse choices, which keeps ties stable.
                while (j > 0 && ranks_ahead(open_set[i], ranked[j-1], frame_on))
                    j--;
                ranked.insert(j, open_set[i]);
            end
            foreach (ranked[i])
            begin
                w.id  = ranked[i].id;
                w.eol = (i == ranked.size() - 1);
                due_ids.push_back(w);
            end
            ids_promised += ranked.size();
            open_set.delete();
        end
    endtask

    // Driver: presents the next queued choice when the channel is free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_choice(on_wire);
            if (!in_valid || in_ready)
            begin
                if (choice_feed.size() != 0
                    && !(choice_feed[0].hold && ids_promised != ids_delivered)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    next_choice = choice_feed.pop_front();
                    on_wire       <= next_choice;
                    choice_id     <= next_choice.id;
                    ems_hole_size <= next_choice.ems_hole;
                    max_hole_size <= next_choice.max_hole;
                    hole_count    <= next_choice.hole_count;
                    frame_address <= next_choice.frame;
                    last          <= next_choice.last;
                    in_valid      <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted id word against the oldest owed one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_ids.size() == 0)
                begin
                    $error("unexpected word: sorted_id %0d end_of_list %0d",
                           sorted_id, end_of_list);
                    mismatches++;
                end
                else
                begin
                    want = due_ids.pop_front();
                    if (sorted_id !== want.id)
                    begin
                        $error("sorted_id: expected %0d, got %0d", want.id, sorted_id);
                        mismatches++;
                    end
                    if (end_of_list !== want.eol)
                    begin
                        $error("end_of_list: expected %0d, got %0d", want.eol, end_of_list);
                        mismatches++;
                    end
                    ids_delivered <= ids_delivered + 1;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_pace(input int idle_pct, input int stall_pct);
        @(posedge clk);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
    endtask

    task automatic write_frame_present(input bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frame_on  <= v;
        // Queue pushes happen away from the driving edge.
        @(negedge clk);
    endtask

    task automatic add_choice(input bit [ID_W-1:0] id, input bit [EMS_W-1:0] ems,
                              input bit [MAXH_W-1:0] maxh, input bit [CNT_W-1:0] cnt,
                              input bit [FRAME_W-1:0] frame, input bit is_last,
                              input bit hold);
        choice_t c;
        c.id         = id;
        c.ems_hole   = ems;
        c.max_hole   = maxh;
        c.hole_count = cnt;
        c.frame      = frame;
        c.last       = is_last;
        c.hold       = hold;
        choice_feed.push_back(c);
    endtask

    // Keys come often from a few values so that ties at every level are common.
    task automatic queue_random_set(input int n);
        bit [EMS_W-1:0]   ems;
        bit [MAXH_W-1:0]  maxh;
        bit [CNT_W-1:0]   cnt;
        bit [FRAME_W-1:0] frame;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:       ems = EMS_W'($urandom_range(2));
                1:       ems = '1;
                default: ems = EMS_W'($urandom);
            endcase
            case ($urandom_range(3))
                0:       maxh = MAXH_W'($urandom_range(2));
                1:       maxh = '1;
                default: maxh = MAXH_W'($urandom);
            endcase
            case ($urandom_range(3))
                0:       cnt = CNT_W'($urandom_range(2));
                1:       cnt = '1;
                default: cnt = CNT_W'($urandom);
            endcase
            case ($urandom_range(3))
                0:       frame = FRAME_W'($urandom_range(1));
                1:       frame = '1;
                default: frame = FRAME_W'($urandom);
            endcase
            add_choice(ID_W'($urandom_range(63)), ems, maxh, cnt, frame, i == n - 1,
                       i == 0 && $urandom_range(3) == 0);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (choice_feed.size() != 0 || in_valid || ids_promised != ids_delivered);
        // The frame tie break takes a full pass over the chain.
        repeat (CAPACITY + 16) @(posedge clk);
    endtask

    initial
    begin
        int added;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Primary keys only; a frame difference must not reorder ties.
        set_pace(0, 0);
        write_frame_present(1'b0);
        add_choice(63, '1, '1, '1, '1, 1'b1, 1'b0);
        add_choice(0, 0, 0, 0, 0, 1'b0, 1'b1);
        add_choice(1, '1, 0, 0, 0, 1'b0, 1'b0);
        add_choice(2, 5, '1, 0, 0, 1'b0, 1'b0);
        add_choice(3, 5, 7, '1, 0, 1'b0, 1'b0);
        add_choice(4, 5, 7, 0, '1, 1'b0, 1'b0);
        add_choice(5, 5, 7, 0, 0, 1'b0, 1'b0);
        add_choice(5, 0, 0, 0, 0, 1'b0, 1'b0);
        add_choice(6, 5, 7, 0, '1, 1'b1, 1'b0);
        drain();

        // Frame address tie break on, with full ties still in arrival order.
        write_frame_present(1'b1);
        add_choice(10, 9, 9, 9, 0, 1'b0, 1'b0);
        add_choice(11, 9, 9, 9, '1, 1'b0, 1'b0);
        add_choice(12, 9, 9, 9, 20'h80000, 1'b0, 1'b0);
        add_choice(13, 9, 9, 9, '1, 1'b0, 1'b0);
        add_choice(14, 9, 9, 8, 0, 1'b0, 1'b0);
        add_choice(15, 9, 9, 9, 1, 1'b1, 1'b0);
        add_choice(0, 0, 0, 0, 0, 1'b1, 1'b0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       set_pace(85, 0);
                1:       set_pace(0, 85);
                2:       set_pace(24, 24);
                default: set_pace(0, 0);
            endcase
            write_frame_present(1'(p % 2));
            added = 0;
            while (added < 24)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                queue_random_set(n);
                added += n;
            end
            // Full chain, then sets whose extra words are dropped, the closing one too.
            if (p == 1)
                queue_random_set(CAPACITY);
            if (p == 2)
                queue_random_set(CAPACITY + 1);
            if (p == 3)
                queue_random_set(CAPACITY + 6);
            drain();
        end

        @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ multi_key_choice_sorter.f @@
rtl/core/mkcs_pkg.sv
rtl/core/mkcs_cell.sv
rtl/core/mkcs_ctrl.sv
rtl/core/multi_key_choice_sorter.sv
bench/multi_key_choice_sorter_tb.sv
